[rtl/core/pcs_pkg.sv]
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared widths, register indexes and reset values for the contrast stretch.
// ----------------------------------------------------------------------------
`default_nettype none

package pcs_pkg;

  localparam int PIX_W      = 8;
  localparam int FRAC_W     = 9;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 9;

  localparam int FRAC_ONE   = 256;
  localparam int FULL_WHITE = 255;
  localparam int LUT_DEPTH  = 1 << PIX_W;
  localparam int OUTQ_DEPTH = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_LOW_LEVEL     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_LEVEL    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KNEE_FRACTION = 2'd2;

  localparam logic [PIX_W-1:0]  RST_LOW_LEVEL     = 8'd100;
  localparam logic [PIX_W-1:0]  RST_HIGH_LEVEL    = 8'd185;
  localparam logic [FRAC_W-1:0] RST_KNEE_FRACTION = 9'd128;

endpackage

`default_nettype wire

[rtl/core/pcs_ram.sv]
// ----------------------------------------------------------------------------
// pcs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/piecewise_contrast_stretch_top.sv]
// ----------------------------------------------------------------------------
// piecewise_contrast_stretch_top
// Two-segment gray tone curve, applied through a 256-entry lookup RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pixel per transaction, in_tdata = pixel_in.
//   out_* : one pixel per transaction, out_tdata = pixel_out.
//   cfg_* : register writes (0 low level, 1 high level, 2 knee fraction).
// After reset and after every register write the curve is rebuilt into the
// lookup RAM, one entry at a time: the knee first, then each entry, mapped
// directly or, on a ramp, through an 8-step restoring divider. in_tready
// stays low during a rebuild.
// Once built, throughput is one pixel per clock while the queue has room.
// Each pixel goes through the RAM read register, then the output queue.
// A 4-entry output queue absorbs the RAM read in flight; in_tready depends
// only on registers and drops when the queue plus the read in flight are
// full, so a stalled receiver backs up the input without losing pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_contrast_stretch_top (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [pcs_pkg::PIX_W-1:0]         in_tdata,   // [7:0] pixel_in
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [pcs_pkg::PIX_W-1:0]        out_tdata,  // [7:0] pixel_out
  input  wire                              cfg_we,
  input  wire [pcs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire [pcs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int PW = pcs_pkg::PIX_W;
  localparam int FW = pcs_pkg::FRAC_W;
  localparam int QD = pcs_pkg::OUTQ_DEPTH;
  localparam int QA = $clog2(QD);
  localparam int QC = $clog2(QD + 1);
  localparam int DC = $clog2(PW);

  localparam logic [1:0] S_KNEE  = 2'd0;
  localparam logic [1:0] S_ENTRY = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_RUN   = 2'd3;

  // configuration
  logic [PW-1:0] low_r,  low_nxt;
  logic [PW-1:0] high_r, high_nxt;
  logic [FW-1:0] knee_r, knee_nxt;
  logic          cfg_hit;

  // curve builder
  logic [1:0]    state_r, state_nxt;
  logic [PW-1:0] ent_r, ent_nxt;
  logic [DC-1:0] div_cnt_r, div_cnt_nxt;
  logic [PW-1:0] kx_r, ky_r, up_gain_r, lo_span_r, hi_span_r;
  logic [PW-1:0] rem_r, qsh_r, den_r, off_r;
  logic [PW-1:0] kx_nxt, ky_nxt, up_gain_nxt, lo_span_nxt, hi_span_nxt;
  logic [PW-1:0] rem_nxt, qsh_nxt, den_nxt, off_nxt;

  logic [FW-1:0]   frac_sat;
  logic [FW-1:0]   frac_rest;
  logic [PW-1:0]   span;
  logic [2*PW-1:0] knee_prod;

  logic            below, above, lower_seg, step_bit;
  logic [PW-1:0]   mul_a, mul_b, direct_val, quot;
  logic [2*PW-1:0] ent_prod;
  logic [PW:0]     trial;

  logic          ram_we;
  logic [PW-1:0] ram_wdata, ram_rdata;

  // run datapath
  logic          s1_vld_r;
  logic [PW-1:0] q_mem_r [QD];
  logic [QA-1:0] q_wr_r, q_rd_r;
  logic [QC-1:0] q_cnt_r, occ;
  logic          push, pop;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    knee_nxt = knee_r;
    cfg_hit  = 1'b0;
    if (cfg_we) begin
      unique case (cfg_addr)
        pcs_pkg::REG_LOW_LEVEL: begin
          low_nxt = cfg_wdata[PW-1:0];
          cfg_hit = 1'b1;
        end
        pcs_pkg::REG_HIGH_LEVEL: begin
          high_nxt = cfg_wdata[PW-1:0];
          cfg_hit  = 1'b1;
        end
        pcs_pkg::REG_KNEE_FRACTION: begin
          knee_nxt = cfg_wdata[FW-1:0];
          cfg_hit  = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Knee setup
  // --------------------------------------------------------------------------
  always_comb begin
    frac_sat  = (knee_r > FW'(pcs_pkg::FRAC_ONE)) ? FW'(pcs_pkg::FRAC_ONE) : knee_r;
    frac_rest = FW'(pcs_pkg::FRAC_ONE) - frac_sat;
    span      = high_r - low_r;
    knee_prod = (2*PW)'(span) * (2*PW)'(frac_sat);
    // 255*g/256 floors to g - 1 for g in 1..256
    ky_nxt      = PW'(frac_rest - FW'(frac_rest != '0));
    lo_span_nxt = knee_prod[2*PW-1:PW];
    kx_nxt      = lo_span_nxt + low_r;
    hi_span_nxt = span - lo_span_nxt;
    up_gain_nxt = PW'(pcs_pkg::FULL_WHITE) - ky_nxt;
  end

  // --------------------------------------------------------------------------
  // Per-entry mapping and divider step
  // --------------------------------------------------------------------------
  always_comb begin
    below      = ent_r < low_r;
    above      = ent_r > high_r;
    lower_seg  = ent_r < kx_r;
    mul_a      = lower_seg ? (ent_r - low_r) : (ent_r - kx_r);
    mul_b      = lower_seg ? ky_r : up_gain_r;
    ent_prod   = (2*PW)'(mul_a) * (2*PW)'(mul_b);
    direct_val = below ? '0 : (above ? PW'(pcs_pkg::FULL_WHITE) : ky_r);

    trial    = {rem_r, qsh_r[PW-1]};
    step_bit = trial >= {1'b0, den_r};
    quot     = {qsh_r[PW-2:0], step_bit};
  end

  always_comb begin
    state_nxt   = state_r;
    ent_nxt     = ent_r;
    div_cnt_nxt = div_cnt_r;
    rem_nxt     = rem_r;
    qsh_nxt     = qsh_r;
    den_nxt     = den_r;
    off_nxt     = off_r;
    ram_we      = 1'b0;
    ram_wdata   = direct_val;
    unique case (state_r)
      S_KNEE: begin
        ent_nxt   = '0;
        state_nxt = S_ENTRY;
      end
      S_ENTRY: begin
        if (below || above || (!lower_seg && hi_span_r == '0)) begin
          ram_we  = 1'b1;
          ent_nxt = ent_r + 1'b1;
          if (ent_r == '1) begin
            state_nxt = S_RUN;
          end
        end else begin
          rem_nxt     = ent_prod[2*PW-1:PW];
          qsh_nxt     = ent_prod[PW-1:0];
          den_nxt     = lower_seg ? lo_span_r : hi_span_r;
          off_nxt     = lower_seg ? '0 : ky_r;
          div_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt     = step_bit ? PW'(trial - {1'b0, den_r}) : trial[PW-1:0];
        qsh_nxt     = quot;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DC'(PW - 1)) begin
          ram_we    = 1'b1;
          ram_wdata = quot + off_r;
          ent_nxt   = ent_r + 1'b1;
          state_nxt = (ent_r == '1) ? S_RUN : S_ENTRY;
        end
      end
      S_RUN: begin
        state_nxt = S_RUN;
      end
      default: begin
        state_nxt = S_KNEE;
      end
    endcase
    if (cfg_hit) begin
      state_nxt = S_KNEE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r     <= pcs_pkg::RST_LOW_LEVEL;
      high_r    <= pcs_pkg::RST_HIGH_LEVEL;
      knee_r    <= pcs_pkg::RST_KNEE_FRACTION;
      state_r   <= S_KNEE;
      ent_r     <= '0;
      div_cnt_r <= '0;
    end else begin
      low_r     <= low_nxt;
      high_r    <= high_nxt;
      knee_r    <= knee_nxt;
      state_r   <= state_nxt;
      ent_r     <= ent_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_KNEE) begin
      kx_r      <= kx_nxt;
      ky_r      <= ky_nxt;
      up_gain_r <= up_gain_nxt;
      lo_span_r <= lo_span_nxt;
      hi_span_r <= hi_span_nxt;
    end
    rem_r <= rem_nxt;
    qsh_r <= qsh_nxt;
    den_r <= den_nxt;
    off_r <= off_nxt;
  end

  // --------------------------------------------------------------------------
  // Curve RAM (builder writes, pixel stream reads; never both at once)
  // --------------------------------------------------------------------------
  pcs_ram #(
    .WIDTH (PW),
    .DEPTH (pcs_pkg::LUT_DEPTH)
  ) u_lut (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ent_r),
    .wdata (ram_wdata),
    .raddr (in_tdata),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Output queue
  // --------------------------------------------------------------------------
  assign occ        = q_cnt_r + QC'(s1_vld_r);
  assign in_tready  = (state_r == S_RUN) && (occ < QC'(QD));
  assign push       = s1_vld_r;
  assign out_tvalid = q_cnt_r != '0;
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = q_mem_r[q_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      q_wr_r   <= '0;
      q_rd_r   <= '0;
      q_cnt_r  <= '0;
    end else begin
      s1_vld_r <= in_tvalid && in_tready;
      if (push) begin
        q_wr_r <= q_wr_r + 1'b1;
      end
      if (pop) begin
        q_rd_r <= q_rd_r + 1'b1;
      end
      q_cnt_r <= q_cnt_r + QC'(push) - QC'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[q_wr_r] <= ram_rdata;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= QC'(QD))
    else $error("output queue overflow");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |=> q_cnt_r != '0)
    else $error("RAM read result lost");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < den_r)
    else $error("divider remainder out of range");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_cnt_r == DC'(PW - 1)) |=>
      (state_r == S_ENTRY || state_r == S_RUN || state_r == S_KNEE))
    else $error("divider did not finish");

endmodule

`default_nettype wire
